/* src/transition_trace_checker_unit_assert.svh */
// Assertion macros shared by the transition trace checker RTL.
`ifndef TRANSITION_TRACE_CHECKER_UNIT_ASSERT_SVH
`define TRANSITION_TRACE_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define TTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transition trace checker: check failed");

// Next-cycle implication, checked out of reset
`define TTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transition trace checker: check failed");

`endif

/* src/ttc_pkg.sv */
// Package: types, constants and helpers for the transition trace checker.
`default_nettype none

package ttc_pkg;

    // Number of call identifiers covered by the edge matrix
    localparam int CALL_COUNT = 16;
    localparam int ID_W       = 4;
    localparam int ROW_W      = (CALL_COUNT > 1) ? $clog2(CALL_COUNT) : 1;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_ADD_EDGE = 2'd1,
        OP_TRACE    = 2'd2
    } op_t;

    typedef logic [ID_W-1:0]       call_id_t;
    typedef logic [CALL_COUNT-1:0] row_t;
    typedef logic [ROW_W-1:0]      row_idx_t;

    // Matrix update request
    typedef struct packed {
        logic     clear;
        logic     add;
        call_id_t src;
        call_id_t dst;
    } matrix_cmd_t;

    // One trace element presented to the tracker
    typedef struct packed {
        logic     step;
        logic     last;
        call_id_t id;
    } trace_cmd_t;

    // Identifier lies inside the matrix
    function automatic logic id_in_range(call_id_t id);
        return (32'(id) < 32'(CALL_COUNT));
    endfunction

    // Identifier resized to a matrix row or column index
    function automatic row_idx_t row_index(call_id_t id);
        return row_idx_t'(id);
    endfunction

endpackage

`default_nettype wire

/* src/ttc_matrix.sv */
// Allowed-transition bit matrix with clear, edge set and single-bit lookup.
`default_nettype none

module ttc_matrix
    import ttc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire matrix_cmd_t cmd,
    input  wire call_id_t    look_src,
    input  wire call_id_t    look_dst,
    output logic             allowed
);

    row_t rows_reg  [CALL_COUNT];
    row_t rows_next [CALL_COUNT];
    logic edge_ok;

    assign edge_ok = id_in_range(cmd.src) && id_in_range(cmd.dst);

    // Row updates: clear wins, otherwise set one bit of the addressed row
    always_comb
    begin
        for (int r = 0; r < CALL_COUNT; r++)
        begin
            if (cmd.clear)
            begin
                rows_next[r] = '0;
            end
            else if (cmd.add && edge_ok && (row_index(cmd.src) == row_idx_t'(r)))
            begin
                rows_next[r] = rows_reg[r] | (row_t'(1) << row_index(cmd.dst));
            end
            else
            begin
                rows_next[r] = rows_reg[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < CALL_COUNT; r++)
            begin
                rows_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r < CALL_COUNT; r++)
            begin
                rows_reg[r] <= rows_next[r];
            end
        end
    end

    // Lookup; out-of-range endpoints never match
    always_comb
    begin
        if (id_in_range(look_src) && id_in_range(look_dst))
        begin
            allowed = rows_reg[row_index(look_src)][row_index(look_dst)];
        end
        else
        begin
            allowed = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* src/ttc_tracker.sv */
// Trace state: previous identifier, open-trace flag and sticky pass flag.
`default_nettype none

`include "transition_trace_checker_unit_assert.svh"

module ttc_tracker
    import ttc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire trace_cmd_t cmd,
    input  wire logic       edge_allowed,
    output call_id_t        prev_call,
    output logic            verdict
);

    call_id_t prev_call_reg, prev_call_next;
    logic     mid_trace_reg, mid_trace_next;
    logic     pass_reg, pass_next;

    assign prev_call = prev_call_reg;

    // Pass flag including the transition into this element
    assign verdict = pass_reg & ~(mid_trace_reg & ~edge_allowed);

    always_comb
    begin
        prev_call_next = prev_call_reg;
        mid_trace_next = mid_trace_reg;
        pass_next      = pass_reg;
        if (cmd.step)
        begin
            prev_call_next = cmd.id;
            if (cmd.last)
            begin
                mid_trace_next = 1'b0;
                pass_next      = 1'b1;
            end
            else
            begin
                mid_trace_next = 1'b1;
                pass_next      = verdict;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_call_reg <= '0;
            mid_trace_reg <= 1'b0;
            pass_reg      <= 1'b1;
        end
        else
        begin
            prev_call_reg <= prev_call_next;
            mid_trace_reg <= mid_trace_next;
            pass_reg      <= pass_next;
        end
    end

    // No trace open means a fresh pass flag
    `TTC_ASSERT_NOW(a_idle_pass, !mid_trace_reg, pass_reg)
    // Closing element leaves no trace open
    `TTC_ASSERT_NEXT(a_close, cmd.step && cmd.last, !mid_trace_reg && pass_reg)
    // Any other element keeps the trace open
    `TTC_ASSERT_NEXT(a_open, cmd.step && !cmd.last, mid_trace_reg)

endmodule

`default_nettype wire

/* src/transition_trace_checker_unit.sv */
// Top level of the transition trace checker: input register, matrix, tracker, result register.
// A closing trace element is held in the input register; its result is then registered for output.
// Throughput: one item per cycle; input stalls only when a closing trace element meets
// a full result register whose transfer is stalled.
// Edge matrix is a 16 x 16 flip-flop array; clear and edge set are registered.
// Reset (rst_n low, asynchronous): no edges allowed, no trace open, pass flag set,
// input and result registers empty.
`default_nettype none

`include "transition_trace_checker_unit_assert.svh"

module transition_trace_checker_unit
    import ttc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] operation,
    input  wire logic [3:0] edge_source,
    input  wire logic [3:0] edge_target,
    input  wire logic [3:0] call_id,
    input  wire logic       trace_end,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            trace_valid
);

    // Input register
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_op_reg;
    call_id_t   s1_src_reg, s1_dst_reg, s1_id_reg;
    logic       s1_end_reg;

    // Result register
    logic       res_valid_reg, res_valid_next;
    logic       res_data_reg, res_data_next;

    matrix_cmd_t mcmd;
    trace_cmd_t  tcmd;
    call_id_t    prev_call;
    logic        edge_allowed;
    logic        verdict;
    logic        is_clear, is_add, is_trace;
    logic        produces, advance, fire;

    // Decode
    always_comb
    begin
        is_clear = 1'b0;
        is_add   = 1'b0;
        is_trace = 1'b0;
        case (op_t'(s1_op_reg))
            OP_CLEAR:    is_clear = 1'b1;
            OP_ADD_EDGE: is_add   = 1'b1;
            OP_TRACE:    is_trace = 1'b1;
            default:     ;
        endcase
    end

    // Flow control: only a closing element needs room in the result register
    assign produces   = is_trace & s1_end_reg;
    assign advance    = ~produces | ~res_valid_reg | ~result_stall;
    assign fire       = s1_valid_reg & advance;
    assign item_stall = s1_valid_reg & ~advance;

    assign mcmd = '{clear: fire & is_clear, add: fire & is_add,
                    src: s1_src_reg, dst: s1_dst_reg};
    assign tcmd = '{step: fire & is_trace, last: s1_end_reg, id: s1_id_reg};

    ttc_matrix u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mcmd),
        .look_src (prev_call),
        .look_dst (s1_id_reg),
        .allowed  (edge_allowed)
    );

    ttc_tracker u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (tcmd),
        .edge_allowed (edge_allowed),
        .prev_call    (prev_call),
        .verdict      (verdict)
    );

    // Input register control
    assign s1_valid_next = item_stall ? s1_valid_reg : item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_op_reg  <= operation;
            s1_src_reg <= edge_source;
            s1_dst_reg <= edge_target;
            s1_id_reg  <= call_id;
            s1_end_reg <= trace_end;
        end
    end

    // Result register: load on a closing element, drop after transfer
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (fire && produces)
        begin
            res_valid_next = 1'b1;
            res_data_next  = verdict;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign result_valid = res_valid_reg;
    assign trace_valid  = res_data_reg;

    // Input stalls only behind a blocked result
    `TTC_ASSERT_NOW(a_stall_cause, item_stall,
        s1_valid_reg && produces && res_valid_reg && result_stall)
    // Matrix operations never stall
    `TTC_ASSERT_NOW(a_matrix_flow, s1_valid_reg && !is_trace, !item_stall)
    // A closing element always yields a result
    `TTC_ASSERT_NEXT(a_result_out, fire && produces, res_valid_reg)

endmodule

`default_nettype wire

/* dv/tb_transition_trace_checker_unit.sv */
// Self-checking testbench for the transition trace checker: directed and random items, scoreboard.
`timescale 1ns / 1ps

module tb_transition_trace_checker_unit;
    import ttc_pkg::*;

    // Operation code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS     = 1750;
    localparam int LONG_HOLD_AT     = 60;    // verdict count at which the receiver holds off
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DRAIN_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 8;     // margin for the last result to arrive
    localparam int PRINT_LIMIT      = 20;

    // Mirror of the block: edge matrix, open trace and the verdicts still owed
    class verdict_board;
        row_t     allowed_rows [CALL_COUNT];
        call_id_t prev_call;
        bit       trace_open;
        bit       pass_so_far;
        bit       pending_verdicts [$];
        int       mismatch_count;
        int       passed_count;
        int       failed_count;

        function new();
            foreach (allowed_rows[i])
                allowed_rows[i] = '0;
            prev_call   = '0;
            trace_open  = 1'b0;
            pass_so_far = 1'b1;
        endfunction

        // Apply one accepted transfer; a closing trace element owes a verdict
        function void note_item(logic [1:0] op, call_id_t src, call_id_t dst,
                                call_id_t id, logic last);
            if (op == OP_CLEAR) begin
                foreach (allowed_rows[i])
                    allowed_rows[i] = '0;
            end
            else if (op == OP_ADD_EDGE) begin
                // identifiers always fall inside a 16-entry matrix
                if (int'(src) < CALL_COUNT && int'(dst) < CALL_COUNT)
                    allowed_rows[src][dst] = 1'b1;
            end
            else if (op == OP_TRACE) begin
                if (trace_open && !allowed_rows[prev_call][id])
                    pass_so_far = 1'b0;
                prev_call  = id;
                trace_open = 1'b1;
                if (last) begin
                    pending_verdicts.push_back(pass_so_far);
                    trace_open  = 1'b0;
                    pass_so_far = 1'b1;
                end
            end
        endfunction

        task report(string what);
            if (mismatch_count < PRINT_LIMIT)
                $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatch_count++;
        endtask

        // Compare one transferred verdict with the oldest one owed
        task check_verdict(logic got);
            bit exp_verdict;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("verdict %0b with none owed", got));
            end
            else begin
                exp_verdict = pending_verdicts.pop_front();
                if (got !== exp_verdict)
                    report($sformatf("trace_valid %0b, expected %0b", got, exp_verdict));
                else if (exp_verdict)
                    passed_count++;
                else
                    failed_count++;
            end
        endtask
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_stall;
    logic [1:0] operation    = '0;
    logic [3:0] edge_source  = '0;
    logic [3:0] edge_target  = '0;
    logic [3:0] call_id      = '0;
    logic       trace_end    = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       trace_valid;

    verdict_board board = new();
    int items_sent;
    int input_hold_cycles;
    bit no_idle;

    transition_trace_checker_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .edge_source  (edge_source),
        .edge_target  (edge_target),
        .call_id      (call_id),
        .trace_end    (trace_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .trace_valid  (trace_valid)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one item after a random gap; fields the operation ignores carry noise
    task send_item(input logic [1:0] op, input call_id_t src, input call_id_t dst,
                   input call_id_t id, input logic last);
        int       gap;
        call_id_t s;
        call_id_t d;
        call_id_t c;
        logic     e;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        s = (op == OP_ADD_EDGE) ? src : call_id_t'($urandom);
        d = (op == OP_ADD_EDGE) ? dst : call_id_t'($urandom);
        c = (op == OP_TRACE) ? id : call_id_t'($urandom);
        e = (op == OP_TRACE) ? last : 1'($urandom);
        if (gap != 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation   <= op;
        edge_source <= s;
        edge_target <= d;
        call_id     <= c;
        trace_end   <= e;
        item_valid  <= 1'b1;
        do begin
            @(posedge clk);
            if (item_stall === 1'b1)
                input_hold_cycles++;
        end while (item_stall !== 1'b0);
        board.note_item(op, s, d, c, e);
        items_sent++;
    endtask

    // Mostly follow an allowed edge so that traces can pass; otherwise jump anywhere
    function automatic call_id_t next_call(call_id_t cur);
        call_id_t options [$];
        for (int j = 0; j < CALL_COUNT; j++)
            if (board.allowed_rows[cur][j])
                options.push_back(call_id_t'(j));
        if (options.size() != 0 && $urandom_range(0, 3) != 0)
            return options[$urandom_range(0, options.size() - 1)];
        return call_id_t'($urandom);
    endfunction

    // Directed: field extremes, every operation, each corner of the trace rules
    task run_directed;
        // lone element closes a trace with nothing to check
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd0, 1'b1);
        // empty matrix: any transition fails
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd15, 1'b0);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd0, 1'b1);
        send_item(OP_UNUSED, 4'd0, 4'd0, 4'd0, 1'b0);
        send_item(OP_ADD_EDGE, 4'd15, 4'd0, 4'd0, 1'b0);
        send_item(OP_ADD_EDGE, 4'd0, 4'd15, 4'd0, 1'b0);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd15, 1'b0);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd0, 1'b0);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd15, 1'b1);
        // edge added while the trace is open
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd3, 1'b0);
        send_item(OP_ADD_EDGE, 4'd3, 4'd7, 4'd0, 1'b0);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd7, 1'b1);
        // matrix cleared while the trace is open
        send_item(OP_ADD_EDGE, 4'd7, 4'd9, 4'd0, 1'b0);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd7, 1'b0);
        send_item(OP_CLEAR, 4'd0, 4'd0, 4'd0, 1'b0);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd9, 1'b1);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd15, 1'b1);
        // self loop, then a step off it
        send_item(OP_ADD_EDGE, 4'd5, 4'd5, 4'd0, 1'b0);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd5, 1'b0);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd5, 1'b0);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd5, 1'b1);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd5, 1'b0);
        send_item(OP_TRACE, 4'd0, 4'd0, 4'd6, 1'b1);
        send_item(OP_UNUSED, 4'd15, 4'd15, 4'd15, 1'b1);
    endtask

    // Random: matrix edits and short traces, with occasional edits inside a trace
    task run_random;
        int       kind;
        int       len;
        call_id_t cur;
        while (items_sent < RANDOM_ITEMS) begin
            no_idle = (items_sent >= 800 && items_sent < 1000);
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                send_item(OP_CLEAR, 4'd0, 4'd0, 4'd0, 1'b0);
            end
            else if (kind <= 4) begin
                repeat ($urandom_range(1, (kind == 1) ? 24 : 5))
                    send_item(OP_ADD_EDGE, call_id_t'($urandom), call_id_t'($urandom),
                              4'd0, 1'b0);
            end
            else if (kind == 5) begin
                send_item(OP_UNUSED, 4'd0, 4'd0, 4'd0, 1'b0);
            end
            else begin
                len = $urandom_range(1, 6);
                cur = call_id_t'($urandom);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 11) == 0)
                        send_item(($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_ADD_EDGE,
                                  call_id_t'($urandom), call_id_t'($urandom), 4'd0, 1'b0);
                    send_item(OP_TRACE, 4'd0, 4'd0, cur, k == len - 1);
                    cur = next_call(cur);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stall per transfer, one long hold-off to back the block up
    initial
    begin
        int hold;
        int seen;
        seen = 0;
        forever begin
            if (seen == LONG_HOLD_AT)
                hold = LONG_HOLD_CYCLES;
            else
                hold = no_idle ? 0 : $urandom_range(0, 3);
            if (hold != 0) begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (result_valid !== 1'b1);
            board.check_verdict(trace_valid);
            seen++;
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Reset, stimulus, drain and verdict
    initial
    begin
        int waited;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed;
        run_random;
        item_valid <= 1'b0;
        waited = 0;
        while (board.pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.pending_verdicts.size() != 0)
            board.report($sformatf("%0d verdicts never arrived",
                                   board.pending_verdicts.size()));
        $display("Run covered %0d items: %0d traces passed, %0d traces failed.",
                 items_sent, board.passed_count, board.failed_count);
        $display("Input side was held off for %0d cycles; %0d mismatches seen.",
                 input_hold_cycles, board.mismatch_count);
        if (board.mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
